@@ rtl/tpst_pkg.sv @@
// ============================================================================
// tpst_pkg: shared types and constants of the triangular pair-sum table
// Request and response payloads, queue command record, register map.
// ============================================================================
`default_nettype none

package tpst_pkg;

    localparam int unsigned CORR_W  = 16;
    localparam int unsigned SUM_W   = 34;
    localparam int unsigned IDX_W   = 10;
    localparam int unsigned CFG_W   = 11;
    localparam int unsigned PDATA_W = 32;
    localparam int unsigned PADDR_W = 3;

    localparam logic [SUM_W-1:0] SUM_MAX      = '1;
    localparam logic [CFG_W-1:0] WINDOW_RESET = 11'd1024;

    // register index, taken from paddr[2]
    localparam logic CFG_IDX_WINDOW = 1'b0;

    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_PTR_W = 2;

    typedef struct packed {
        logic [CORR_W-1:0] corr_value;
        logic              restart;
    } t_in_req;

    typedef struct packed {
        logic [SUM_W-1:0] region_sum;
        logic [IDX_W-1:0] row_index;
        logic [IDX_W-1:0] col_index;
        logic             window_done;
    } t_out_rsp;

    typedef struct packed {
        logic [CORR_W-1:0] corr_value;
        logic [IDX_W-1:0]  row_index;
        logic [IDX_W-1:0]  col_index;
        logic              diag;
        logic              window_done;
    } t_cmd;

endpackage

`default_nettype wire

@@ rtl/tpst_ram.sv @@
// ============================================================================
// tpst_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module tpst_ram #(
    parameter int unsigned WIDTH = 34,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/tpst_front.sv @@
// ============================================================================
// tpst_front: request intake and position tracking
// Tracks row and column of the next pair, classifies diagonal and final
// pairs, and pushes one command per request into the queue.
// ============================================================================
`default_nettype none

module tpst_front #(
    parameter int unsigned MAX_SITES = 1024
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    input  wire tpst_pkg::t_in_req            i_req,
    output logic                              o_stall,
    input  wire logic [tpst_pkg::CFG_W-1:0]   i_window_sites,
    input  wire logic                         i_q_full,
    output logic                              o_push,
    output tpst_pkg::t_cmd                    o_cmd,
    output logic [$clog2(MAX_SITES)-1:0]      o_addr
);

    localparam int unsigned AW = $clog2(MAX_SITES);
    localparam int unsigned WW = $clog2(MAX_SITES + 1);

    logic [AW-1:0] r_row;
    logic [AW-1:0] n_row;
    logic [AW-1:0] r_col;
    logic [AW-1:0] n_col;
    logic [AW-1:0] cur_row;
    logic [AW-1:0] cur_col;
    logic [WW-1:0] w_eff;
    logic [31:0]   win32;
    logic [31:0]   row32;
    logic [31:0]   col32;
    logic          diag;
    logic          last_col;
    logic          done;

    always_comb begin
        win32 = 32'(i_window_sites);
        if (win32 < 32'd2) begin
            w_eff = WW'(2);
        end else if (win32 > 32'(MAX_SITES)) begin
            w_eff = WW'(MAX_SITES);
        end else begin
            w_eff = WW'(win32);
        end

        cur_row  = i_req.restart ? AW'(1) : r_row;
        cur_col  = i_req.restart ? '0 : r_col;
        row32    = 32'(cur_row);
        col32    = 32'(cur_col);
        diag     = (col32 + 32'd1 == row32);
        last_col = (cur_col == '0);
        done     = last_col && (row32 + 32'd1 >= 32'(w_eff));

        n_row = cur_row;
        n_col = cur_col - AW'(1);
        if (last_col) begin
            if (done) begin
                n_row = AW'(1);
                n_col = '0;
            end else begin
                n_row = cur_row + AW'(1);
                n_col = cur_row;
            end
        end

        o_cmd.corr_value  = i_req.corr_value;
        o_cmd.row_index   = row32[tpst_pkg::IDX_W-1:0];
        o_cmd.col_index   = col32[tpst_pkg::IDX_W-1:0];
        o_cmd.diag        = diag;
        o_cmd.window_done = done;
        o_addr            = cur_col;
    end

    assign o_stall = i_q_full;
    assign o_push  = i_valid & ~i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= AW'(1);
            r_col <= '0;
        end else if (o_push) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

endmodule

`default_nettype wire

@@ rtl/tpst_queue.sv @@
// ============================================================================
// tpst_queue: command queue between front and back
// Small register FIFO that decouples request intake from the sum datapath.
// ============================================================================
`default_nettype none

module tpst_queue #(
    parameter int unsigned ADDR_W = 10
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire tpst_pkg::t_cmd    i_cmd,
    input  wire logic [ADDR_W-1:0] i_addr,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic                   o_valid,
    output tpst_pkg::t_cmd         o_cmd,
    output logic [ADDR_W-1:0]      o_addr
);

    localparam int unsigned PW = tpst_pkg::Q_PTR_W;

    tpst_pkg::t_cmd    r_cmd  [tpst_pkg::Q_DEPTH];
    logic [ADDR_W-1:0] r_addr [tpst_pkg::Q_DEPTH];
    logic [PW-1:0]     r_wr_ptr;
    logic [PW-1:0]     r_rd_ptr;
    logic [PW:0]       r_count;
    logic [PW:0]       n_count;

    assign o_full  = (r_count == (PW+1)'(tpst_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_cmd[r_rd_ptr];
    assign o_addr  = r_addr[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + (PW+1)'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - (PW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_cmd[r_wr_ptr]  <= i_cmd;
            r_addr[r_wr_ptr] <= i_addr;
        end
    end

endmodule

`default_nettype wire

@@ rtl/tpst_back.sv @@
// ============================================================================
// tpst_back: region-sum datapath
// Reads the upper sum from the line store, forms the saturating region sum
// against the left and upper-left neighbors, writes it back, and holds the
// response in an output register.
// ============================================================================
`default_nettype none

module tpst_back #(
    parameter int unsigned MAX_SITES = 1024
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_q_valid,
    input  wire tpst_pkg::t_cmd                i_q_cmd,
    input  wire logic [$clog2(MAX_SITES)-1:0]  i_q_addr,
    output logic                               o_q_pop,
    output logic                               o_out_valid,
    output tpst_pkg::t_out_rsp                 o_out_rsp,
    input  wire logic                          i_out_stall
);

    localparam int unsigned AW = $clog2(MAX_SITES);
    localparam int unsigned SW = tpst_pkg::SUM_W;

    logic               r_ex_valid;
    tpst_pkg::t_cmd     r_ex_cmd;
    logic [AW-1:0]      r_ex_addr;
    logic [SW-1:0]      r_left;
    logic [SW-1:0]      r_ul;
    logic               r_out_valid;
    tpst_pkg::t_out_rsp r_out_rsp;

    logic               out_free;
    logic               ex_adv;
    logic               ex_free;
    logic [SW-1:0]      ram_rdata;
    logic [SW-1:0]      up_eff;
    logic [SW-1:0]      left_eff;
    logic [SW-1:0]      ul_eff;
    logic [SW+1:0]      t_sum;
    logic [SW+1:0]      s_raw;
    logic [SW-1:0]      s_sum;

    assign out_free = ~r_out_valid | ~i_out_stall;
    assign ex_adv   = r_ex_valid & out_free;
    assign ex_free  = ~r_ex_valid | ex_adv;
    assign o_q_pop  = i_q_valid & ex_free;

    tpst_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_SITES)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (ex_adv),
        .i_waddr (r_ex_addr),
        .i_wdata (s_sum),
        .i_re    (o_q_pop),
        .i_raddr (i_q_addr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        up_eff   = r_ex_cmd.diag ? '0 : ram_rdata;
        left_eff = r_ex_cmd.diag ? '0 : r_left;
        ul_eff   = r_ex_cmd.diag ? '0 : r_ul;
        t_sum    = (SW+2)'(r_ex_cmd.corr_value) + (SW+2)'(up_eff) + (SW+2)'(left_eff);
        if (t_sum >= (SW+2)'(ul_eff)) begin
            s_raw = t_sum - (SW+2)'(ul_eff);
        end else begin
            s_raw = '0;
        end
        if (up_eff == tpst_pkg::SUM_MAX || left_eff == tpst_pkg::SUM_MAX ||
            s_raw > (SW+2)'(tpst_pkg::SUM_MAX)) begin
            s_sum = tpst_pkg::SUM_MAX;
        end else begin
            s_sum = s_raw[SW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ex_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_left      <= '0;
            r_ul        <= '0;
        end else begin
            if (o_q_pop) begin
                r_ex_valid <= 1'b1;
            end else if (ex_adv) begin
                r_ex_valid <= 1'b0;
            end
            if (ex_adv) begin
                r_out_valid <= 1'b1;
                r_left      <= s_sum;
                r_ul        <= up_eff;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_ex_cmd  <= i_q_cmd;
            r_ex_addr <= i_q_addr;
        end
        if (ex_adv) begin
            r_out_rsp.region_sum  <= s_sum;
            r_out_rsp.row_index   <= r_ex_cmd.row_index;
            r_out_rsp.col_index   <= r_ex_cmd.col_index;
            r_out_rsp.window_done <= r_ex_cmd.window_done;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

endmodule

`default_nettype wire

@@ rtl/triangular_pair_sum_table_core.sv @@
// ============================================================================
// triangular_pair_sum_table_core: streaming summed-area table over a triangle
// Path: accepted requests pass the queue, execute and output registers.
// Throughput: one request per cycle while i_out_stall is low, set by the
// combinational region-sum add that feeds the left-neighbor register.
// Reset: position row 1 column 0, queue and pipeline empty, window 1024;
// the line store is not cleared.
// ============================================================================
`default_nettype none

module triangular_pair_sum_table_core #(
    parameter int unsigned MAX_SITES = 1024
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,

    input  wire logic                           i_in_valid,
    input  wire tpst_pkg::t_in_req              i_in_data,
    output logic                                o_in_stall,

    output logic                                o_out_valid,
    output tpst_pkg::t_out_rsp                  o_out_data,
    input  wire logic                           i_out_stall,

    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [tpst_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [tpst_pkg::PDATA_W-1:0]   pwdata,
    output logic      [tpst_pkg::PDATA_W-1:0]   prdata,
    output logic                                pready
);

    localparam int unsigned AW = $clog2(MAX_SITES);

    logic [tpst_pkg::CFG_W-1:0] r_window;
    logic                       cfg_wr;

    logic                       push;
    logic                       q_full;
    tpst_pkg::t_cmd             f_cmd;
    logic [AW-1:0]              f_addr;
    logic                       pop;
    logic                       q_valid;
    tpst_pkg::t_cmd             q_cmd;
    logic [AW-1:0]              q_addr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & (paddr[2] == tpst_pkg::CFG_IDX_WINDOW);

    always_comb begin
        if (paddr[2] == tpst_pkg::CFG_IDX_WINDOW) begin
            prdata = tpst_pkg::PDATA_W'(r_window);
        end else begin
            prdata = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= tpst_pkg::WINDOW_RESET;
        end else if (cfg_wr) begin
            r_window <= pwdata[tpst_pkg::CFG_W-1:0];
        end
    end

    tpst_front #(
        .MAX_SITES (MAX_SITES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in_valid),
        .i_req          (i_in_data),
        .o_stall        (o_in_stall),
        .i_window_sites (r_window),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_cmd          (f_cmd),
        .o_addr         (f_addr)
    );

    tpst_queue #(
        .ADDR_W (AW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (f_cmd),
        .i_addr  (f_addr),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .o_addr  (q_addr)
    );

    tpst_back #(
        .MAX_SITES (MAX_SITES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .i_q_addr    (q_addr),
        .o_q_pop     (pop),
        .o_out_valid (o_out_valid),
        .o_out_rsp   (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

`default_nettype wire

@@ tb/sv/tpst_sum_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tpst_sum_checker: response checker for the triangular pair-sum table
// Watches the request, response and register channels, keeps its own copy of
// the position, neighbor sums and line store, predicts every response in
// request order and compares it field by field. Also checks register reads.
// ============================================================================

module tpst_sum_checker #(
    parameter int unsigned MAX_SITES = 1024
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,

    input  wire logic                             i_in_valid,
    input  wire tpst_pkg::t_in_req                i_in_data,
    input  wire logic                             i_in_stall,

    input  wire logic                             i_out_valid,
    input  wire tpst_pkg::t_out_rsp               i_out_data,
    input  wire logic                             i_out_stall,

    input  wire logic                             i_psel,
    input  wire logic                             i_penable,
    input  wire logic                             i_pwrite,
    input  wire logic [tpst_pkg::PADDR_W-1:0]     i_paddr,
    input  wire logic [tpst_pkg::PDATA_W-1:0]     i_pwdata,
    input  wire logic [tpst_pkg::PDATA_W-1:0]     i_prdata,
    input  wire logic                             i_pready,

    output int unsigned                           o_fail_count,
    output int unsigned                           o_pending
);

    localparam int unsigned SW = tpst_pkg::SUM_W;

    logic [SW-1:0]              row_store [MAX_SITES];
    logic [SW-1:0]              left_sum;
    logic [SW-1:0]              upleft_sum;
    int unsigned                cur_row;
    int unsigned                cur_col;
    logic [tpst_pkg::CFG_W-1:0] window_cfg;

    tpst_pkg::t_out_rsp         expected_sums [$];
    tpst_pkg::t_out_rsp         want;
    int unsigned                fail_count = 0;
    int unsigned                rsp_count  = 0;

    assign o_fail_count = fail_count;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        fail_count++;
        $display("mismatch at response %0d: %s got %0h, expected %0h",
                 rsp_count, what, got, exp_val);
    endtask

    // one step of the streaming summed-area table
    function automatic tpst_pkg::t_out_rsp next_region_sum(input tpst_pkg::t_in_req req);
        int unsigned        w;
        int unsigned        r;
        int unsigned        c;
        logic [SW-1:0]      up;
        logic [SW-1:0]      lft;
        logic [SW-1:0]      ul;
        logic [SW-1:0]      s;
        logic [SW+1:0]      t;
        logic [SW+1:0]      d;
        logic               done;
        tpst_pkg::t_out_rsp rsp;

        if (window_cfg < 2)
            w = 2;
        else if (window_cfg > MAX_SITES)
            w = MAX_SITES;
        else
            w = window_cfg;

        if (req.restart) begin
            cur_row    = 1;
            cur_col    = 0;
            left_sum   = '0;
            upleft_sum = '0;
        end
        r = cur_row;
        c = cur_col;
        if (r < 1 || r >= MAX_SITES || c >= r) begin
            r = 1;
            c = 0;
        end

        up  = '0;
        lft = '0;
        ul  = '0;
        if (c + 1 != r) begin
            up  = row_store[c];
            lft = left_sum;
            ul  = upleft_sum;
        end

        if (up == tpst_pkg::SUM_MAX || lft == tpst_pkg::SUM_MAX) begin
            s = tpst_pkg::SUM_MAX;
        end else begin
            t = (SW+2)'(req.corr_value) + (SW+2)'(up) + (SW+2)'(lft);
            d = t - (SW+2)'(ul);
            if (t < (SW+2)'(ul))
                s = '0;
            else if (d > (SW+2)'(tpst_pkg::SUM_MAX))
                s = tpst_pkg::SUM_MAX;
            else
                s = d[SW-1:0];
        end
        row_store[c] = s;

        if (c > 0) begin
            done       = 1'b0;
            cur_row    = r;
            cur_col    = c - 1;
            left_sum   = s;
            upleft_sum = up;
        end else begin
            done       = (r + 1 >= w);
            cur_row    = done ? 1 : r + 1;
            cur_col    = cur_row - 1;
            left_sum   = '0;
            upleft_sum = '0;
        end

        rsp.region_sum  = s;
        rsp.row_index   = (tpst_pkg::IDX_W)'(r);
        rsp.col_index   = (tpst_pkg::IDX_W)'(c);
        rsp.window_done = done;
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            left_sum   = '0;
            upleft_sum = '0;
            cur_row    = 1;
            cur_col    = 0;
            window_cfg = tpst_pkg::WINDOW_RESET;
            expected_sums.delete();
        end else begin
            if (i_psel && i_penable && i_pready
                    && i_paddr[tpst_pkg::PADDR_W-1:2] == tpst_pkg::CFG_IDX_WINDOW) begin
                if (i_pwrite)
                    window_cfg = i_pwdata[tpst_pkg::CFG_W-1:0];
                else if (i_prdata !== (tpst_pkg::PDATA_W)'(window_cfg))
                    report_mismatch("window_sites readback", 64'(i_prdata),
                                    64'(window_cfg));
            end

            if (i_in_valid && !i_in_stall)
                expected_sums.push_back(next_region_sum(i_in_data));

            if (i_out_valid && !i_out_stall) begin
                if (expected_sums.size() == 0) begin
                    report_mismatch("response with no request pending",
                                    64'(i_out_data.region_sum), '0);
                end else begin
                    want = expected_sums.pop_front();
                    if (i_out_data.region_sum !== want.region_sum)
                        report_mismatch("region_sum", 64'(i_out_data.region_sum),
                                        64'(want.region_sum));
                    if (i_out_data.row_index !== want.row_index)
                        report_mismatch("row_index", 64'(i_out_data.row_index),
                                        64'(want.row_index));
                    if (i_out_data.col_index !== want.col_index)
                        report_mismatch("col_index", 64'(i_out_data.col_index),
                                        64'(want.col_index));
                    if (i_out_data.window_done !== want.window_done)
                        report_mismatch("window_done", 64'(i_out_data.window_done),
                                        64'(want.window_done));
                end
                rsp_count++;
            end
        end
        o_pending <= expected_sums.size();
    end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ============================================================================
// testbench: regression for triangular_pair_sum_table_core
// Directed requests over the field extremes, window sizes, restarts and a
// window shrunk mid-stream, then random phases with random window sizes,
// idles on both sides and long response hold-offs. Checking is in
// tpst_sum_checker.
// ============================================================================

module testbench;

    localparam int unsigned RANDOM_ITEMS   = 1800;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam logic [tpst_pkg::PADDR_W-1:0] WINDOW_ADDR =
        (tpst_pkg::PADDR_W)'(tpst_pkg::CFG_IDX_WINDOW) << 2;

    logic                             i_clk       = 1'b0;
    logic                             i_rst_n     = 1'b0;
    logic                             i_in_valid  = 1'b0;
    tpst_pkg::t_in_req                i_in_data   = '0;
    logic                             o_in_stall;
    logic                             o_out_valid;
    tpst_pkg::t_out_rsp               o_out_data;
    logic                             i_out_stall = 1'b0;
    logic                             psel        = 1'b0;
    logic                             penable     = 1'b0;
    logic                             pwrite      = 1'b0;
    logic [tpst_pkg::PADDR_W-1:0]     paddr       = '0;
    logic [tpst_pkg::PDATA_W-1:0]     pwdata      = '0;
    logic [tpst_pkg::PDATA_W-1:0]     prdata;
    logic                             pready;

    int unsigned        fail_count;
    int unsigned        pending;
    int unsigned        items_sent  = 0;
    logic               tx_idle_on  = 1'b1;
    logic               rx_idle_on  = 1'b1;
    int unsigned        hold_gen    = 0;
    int unsigned        hold_seen   = 0;
    int unsigned        hold_left   = 0;
    int unsigned        stall_left  = 0;
    int unsigned        quiet_cycles = 0;

    triangular_pair_sum_table_core #(
        .MAX_SITES(1024)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    tpst_sum_checker #(
        .MAX_SITES(1024)
    ) sum_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_data    (i_in_data),
        .i_in_stall   (o_in_stall),
        .i_out_valid  (o_out_valid),
        .i_out_data   (o_out_data),
        .i_out_stall  (i_out_stall),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // mostly short idles, a few long ones
    function automatic int unsigned pick_idle();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 60)
            return 0;
        else if (sel < 90)
            return $urandom_range(1, 3);
        else if (sel < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [tpst_pkg::CFG_W-1:0] pick_window();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            return (tpst_pkg::CFG_W)'($urandom_range(2, 40));
        else if (sel < 7)
            return (tpst_pkg::CFG_W)'($urandom_range(41, 300));
        else if (sel < 9) begin
            case ($urandom_range(0, 5))
                0: return (tpst_pkg::CFG_W)'(0);
                1: return (tpst_pkg::CFG_W)'(1);
                2: return (tpst_pkg::CFG_W)'(2);
                3: return (tpst_pkg::CFG_W)'(3);
                4: return (tpst_pkg::CFG_W)'(1024);
                default: return (tpst_pkg::CFG_W)'(2047);
            endcase
        end else
            return (tpst_pkg::CFG_W)'($urandom);
    endfunction

    // write the window size, then read it back
    task automatic set_window(input logic [tpst_pkg::CFG_W-1:0] sites);
        logic [tpst_pkg::PDATA_W-1:0] data;
        data = ($urandom_range(0, 3) == 0) ? (tpst_pkg::PDATA_W)'($urandom) : '0;
        data[tpst_pkg::CFG_W-1:0] = sites;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= WINDOW_ADDR;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_req(input logic [tpst_pkg::CORR_W-1:0] corr, input logic restart);
        int unsigned gap;
        gap = tx_idle_on ? pick_idle() : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{corr_value: corr, restart: restart};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic run_phase(input int unsigned n, input int unsigned restart_pct);
        logic [tpst_pkg::CORR_W-1:0] corr;
        repeat (n) begin
            case ($urandom_range(0, 7))
                0: corr = 16'h0000;
                1: corr = 16'hFFFF;
                2: corr = 16'h8000;
                default: corr = (tpst_pkg::CORR_W)'($urandom);
            endcase
            send_req(corr, $urandom_range(0, 99) < restart_pct);
        end
        i_in_valid <= 1'b0;
    endtask

    task automatic drain_idle();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // response side: random stalls plus an occasional long hold-off
    always @(posedge i_clk) begin
        if (hold_seen != hold_gen) begin
            hold_seen   <= hold_gen;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (rx_idle_on && $urandom_range(0, 99) < 30) begin
            stall_left  <= pick_idle();
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("triangular_pair_sum_table_core regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int unsigned random_start;
        int unsigned phase;
        int unsigned n;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // small window: extremes, wrap after window end, restart mid-row
        set_window((tpst_pkg::CFG_W)'(4));
        send_req(16'h0000, 1'b1);
        send_req(16'hFFFF, 1'b0);
        send_req(16'h8000, 1'b0);
        send_req(16'h7FFF, 1'b0);
        send_req(16'h0001, 1'b0);
        send_req(16'hFFFF, 1'b0);
        send_req(16'hFFFF, 1'b0);
        send_req(16'h1234, 1'b0);
        send_req(16'hFFFF, 1'b1);
        i_in_valid <= 1'b0;
        drain_idle();

        // window sizes below the minimum and above the maximum
        set_window((tpst_pkg::CFG_W)'(0));
        repeat (2) send_req((tpst_pkg::CORR_W)'($urandom), 1'b0);
        i_in_valid <= 1'b0;
        drain_idle();
        set_window((tpst_pkg::CFG_W)'(1));
        send_req(16'hFFFF, 1'b0);
        i_in_valid <= 1'b0;
        drain_idle();
        set_window((tpst_pkg::CFG_W)'(2047));
        send_req(16'h8000, 1'b1);
        send_req(16'hFFFF, 1'b0);
        i_in_valid <= 1'b0;
        drain_idle();

        // shrink the window while the position is past its last row
        set_window((tpst_pkg::CFG_W)'(64));
        send_req((tpst_pkg::CORR_W)'($urandom), 1'b1);
        repeat (9) send_req((tpst_pkg::CORR_W)'($urandom), 1'b0);
        i_in_valid <= 1'b0;
        drain_idle();
        set_window((tpst_pkg::CFG_W)'(3));
        repeat (5) send_req((tpst_pkg::CORR_W)'($urandom), 1'b0);
        i_in_valid <= 1'b0;
        drain_idle();

        random_start = items_sent;
        phase = 0;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            set_window(pick_window());
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on <= ($urandom_range(0, 3) != 0);
            n = $urandom_range(20, 200);
            if (phase == 1 || phase == 6) begin
                hold_gen   <= hold_gen + 1;
                tx_idle_on = 1'b0;
                n          = 120;
            end
            run_phase(n, ($urandom_range(0, 4) == 0) ? 15 : 2);
            drain_idle();
            phase++;
        end

        if (fail_count == 0 && pending == 0)
            $display("triangular_pair_sum_table_core regression: pass");
        else
            $display("triangular_pair_sum_table_core regression: fail");
        $finish;
    end

endmodule
